[hdl/mfr_pkg.sv]
// Shared constants, codes and types of the meter frame receiver.
`default_nettype none

package mfr_pkg;

    // Frame store depth in bytes (16 to 64).
    localparam int BUF_DEPTH = 64;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam int BYTE_W    = 8;
    localparam int BIDX_W    = 6;
    localparam int TOT_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Frame layout.
    localparam int HDR_SECOND     = 7;
    localparam int LEN_POS        = 9;
    localparam int FRAME_OVERHEAD = 12;
    localparam int CS_OFFSET      = 10;
    localparam int END_OFFSET     = 11;

    localparam logic [BYTE_W-1:0] START_RESET = 8'h68;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'h16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START = 2'd0,
        REG_END   = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_FRAME = 2'd0,
        ST_CSUM  = 2'd1,
        ST_END   = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HUNT,
        S_CHECK,
        S_WALK,
        S_VERDICT,
        S_ERR,
        S_EMIT
    } state_t;

    // Control from the sequencer to the cell chain.
    typedef struct packed {
        logic              shift;
        logic              append;
        logic [IDX_W-1:0]  slot;
        logic [BYTE_W-1:0] din;
    } chain_ctrl_t;

    // Fixed taps of the chain seen by the sequencer.
    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] hdr2;
        logic [BYTE_W-1:0] len;
    } chain_view_t;

endpackage

`default_nettype wire

[hdl/mfr_cell.sv]
// One byte cell of the frame store chain.
`default_nettype none

module mfr_cell (
    input  wire logic                          clk,
    input  wire logic                          shift,
    input  wire logic                          load,
    input  wire logic [mfr_pkg::BYTE_W-1:0]    right_byte,
    input  wire logic [mfr_pkg::BYTE_W-1:0]    load_byte,
    output logic      [mfr_pkg::BYTE_W-1:0]    data
);

    logic [mfr_pkg::BYTE_W-1:0] data_reg;
    logic [mfr_pkg::BYTE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = right_byte;
        end
        else if (load)
        begin
            data_next = load_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

[hdl/mfr_chain.sv]
// Frame store built as a rotating chain of byte cells.
`default_nettype none

module mfr_chain (
    input  wire logic                 clk,
    input  wire mfr_pkg::chain_ctrl_t ctrl,
    output mfr_pkg::chain_view_t      view
);

    logic [mfr_pkg::BYTE_W-1:0] cell_data [mfr_pkg::BUF_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < mfr_pkg::BUF_DEPTH; gi++)
        begin : g_cell
            logic                       load_sel;
            logic [mfr_pkg::BYTE_W-1:0] right_byte;

            // Append lands in the cell right after the held bytes.
            assign load_sel = ctrl.append && (ctrl.slot == mfr_pkg::IDX_W'(gi));
            // Tail takes the head, so a shift is a rotation.
            assign right_byte = cell_data[(gi + 1) % mfr_pkg::BUF_DEPTH];

            mfr_cell u_cell (
                .clk        (clk),
                .shift      (ctrl.shift),
                .load       (load_sel),
                .right_byte (right_byte),
                .load_byte  (ctrl.din),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    assign view.head = cell_data[0];
    assign view.hdr2 = cell_data[mfr_pkg::HDR_SECOND];
    assign view.len  = cell_data[mfr_pkg::LEN_POS];

endmodule

`default_nettype wire

[hdl/meter_frame_receiver.sv]
// Top level of the meter frame receiver: sequencer, result register and checks.
// Sequence: an accepted byte is appended; the hunt drops leading bytes one by one until a
//   header fits, then the length check runs; a complete frame adds a checksum walk over
//   the whole store and a verdict, a too-long length goes straight to its error result.
// Throughput: one byte at a time; the next byte is taken only in idle, once the last result
//   is loaded, so results that stall hold off the input.
// Reset: rst_n clears control, fill count, output valid; markers reset; store undefined.
`default_nettype none

module meter_frame_receiver (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input item stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
    // Result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [15:0]                       m_axis_tdata,   // [7:0] out_byte,
                                                                   // [13:8] byte_index,
                                                                   // [15:14] zero
    output logic                                   m_axis_tlast,   // last
    output logic      [1:0]                        m_axis_tuser,   // [1:0] status
    // Configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [mfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mfr_pkg::BYTE_W-1:0]        cfg_data
);

    localparam int BW = mfr_pkg::BYTE_W;
    localparam int TW = mfr_pkg::TOT_W;

    // Sequencer state
    mfr_pkg::state_t              state_reg, state_next;
    logic [mfr_pkg::CNT_W-1:0]    fill_reg, fill_next;
    logic                         done_reg, done_next;       // verdict given for this byte
    logic [mfr_pkg::IDX_W-1:0]    walk_reg, walk_next;       // rotation step of the walk
    logic [BW-1:0]                sum_reg, sum_next;
    logic [BW-1:0]                cs_reg, cs_next;
    logic [BW-1:0]                endb_reg, endb_next;
    logic [BW-1:0]                len_reg, len_next;
    mfr_pkg::status_t             err_reg, err_next;
    logic [mfr_pkg::BIDX_W-1:0]   emit_reg, emit_next;

    // Configuration
    logic [BW-1:0]                start_reg, start_next;
    logic [BW-1:0]                end_reg, end_next;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic [BW-1:0]                out_byte_reg, out_byte_next;
    logic [mfr_pkg::BIDX_W-1:0]   out_idx_reg, out_idx_next;
    logic                         out_last_reg, out_last_next;
    mfr_pkg::status_t             out_status_reg, out_status_next;

    mfr_pkg::chain_ctrl_t         chain_ctrl;
    mfr_pkg::chain_view_t         chain_view;

    logic                         in_fire;
    logic                         can_load;
    logic                         hunt_drop;
    logic [TW-1:0]                fill_wide;
    logic [TW-1:0]                view_total;
    logic [TW-1:0]                walk_wide;
    logic [TW-1:0]                cs_pos;
    logic [TW-1:0]                end_pos;
    logic [TW-1:0]                frame_total;
    logic                         emit_last;
    logic                         verdict_bad;

    mfr_chain u_chain (
        .clk  (clk),
        .ctrl (chain_ctrl),
        .view (chain_view)
    );

    assign s_axis_tready = (state_reg == mfr_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    // Result register is free when empty or being drained this cycle.
    assign can_load      = !out_valid_reg || m_axis_tready;

    // Drop the head while it is no start byte, or while the second start byte is wrong.
    assign hunt_drop = ((fill_reg != '0) && (chain_view.head != start_reg)) ||
                       ((fill_reg > mfr_pkg::CNT_W'(mfr_pkg::HDR_SECOND)) &&
                        (chain_view.hdr2 != start_reg));

    assign fill_wide   = TW'(fill_reg);
    assign view_total  = TW'(chain_view.len) + TW'(mfr_pkg::FRAME_OVERHEAD);
    assign walk_wide   = TW'(walk_reg);
    assign cs_pos      = TW'(len_reg) + TW'(mfr_pkg::CS_OFFSET);
    assign end_pos     = TW'(len_reg) + TW'(mfr_pkg::END_OFFSET);
    assign frame_total = TW'(len_reg) + TW'(mfr_pkg::FRAME_OVERHEAD);
    assign emit_last   = (TW'(emit_reg) == frame_total - TW'(1));
    assign verdict_bad = (endb_reg != end_reg) || (sum_reg != cs_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfr_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = mfr_pkg::S_HUNT;
                end
            end
            mfr_pkg::S_HUNT:
            begin
                if (!hunt_drop)
                begin
                    state_next = done_reg ? mfr_pkg::S_IDLE : mfr_pkg::S_CHECK;
                end
            end
            mfr_pkg::S_CHECK:
            begin
                priority if (fill_reg <= mfr_pkg::CNT_W'(mfr_pkg::LEN_POS))
                begin
                    state_next = mfr_pkg::S_IDLE;
                end
                else if (view_total > TW'(mfr_pkg::BUF_DEPTH))
                begin
                    state_next = mfr_pkg::S_ERR;
                end
                else if (fill_wide < view_total)
                begin
                    state_next = mfr_pkg::S_IDLE;
                end
                else
                begin
                    state_next = mfr_pkg::S_WALK;
                end
            end
            mfr_pkg::S_WALK:
            begin
                // A full rotation restores the store order.
                if (walk_reg == mfr_pkg::IDX_W'(mfr_pkg::BUF_DEPTH - 1))
                begin
                    state_next = mfr_pkg::S_VERDICT;
                end
            end
            mfr_pkg::S_VERDICT:
            begin
                state_next = verdict_bad ? mfr_pkg::S_ERR : mfr_pkg::S_EMIT;
            end
            mfr_pkg::S_ERR:
            begin
                if (can_load)
                begin
                    state_next = mfr_pkg::S_HUNT;
                end
            end
            mfr_pkg::S_EMIT:
            begin
                if (can_load && emit_last)
                begin
                    state_next = mfr_pkg::S_HUNT;
                end
            end
            default:
            begin
                state_next = mfr_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and chain control
    always_comb
    begin
        fill_next       = fill_reg;
        done_next       = done_reg;
        walk_next       = walk_reg;
        sum_next        = sum_reg;
        cs_next         = cs_reg;
        endb_next       = endb_reg;
        len_next        = len_reg;
        err_next        = err_reg;
        emit_next       = emit_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        chain_ctrl.shift  = 1'b0;
        chain_ctrl.append = 1'b0;
        chain_ctrl.slot   = fill_reg[mfr_pkg::IDX_W-1:0];
        chain_ctrl.din    = s_axis_tdata;

        unique case (state_reg)
            mfr_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    // Append the byte behind the held ones.
                    chain_ctrl.append = 1'b1;
                    fill_next         = fill_reg + mfr_pkg::CNT_W'(1);
                    done_next         = 1'b0;
                end
            end
            mfr_pkg::S_HUNT:
            begin
                if (hunt_drop)
                begin
                    chain_ctrl.shift = 1'b1;
                    fill_next        = fill_reg - mfr_pkg::CNT_W'(1);
                end
            end
            mfr_pkg::S_CHECK:
            begin
                len_next  = chain_view.len;
                err_next  = mfr_pkg::ST_LONG;
                walk_next = '0;
                sum_next  = '0;
            end
            mfr_pkg::S_WALK:
            begin
                // Head holds byte number walk_reg of the frame.
                chain_ctrl.shift = 1'b1;
                walk_next        = walk_reg + mfr_pkg::IDX_W'(1);
                if (walk_wide < cs_pos)
                begin
                    sum_next = sum_reg + chain_view.head;
                end
                if (walk_wide == cs_pos)
                begin
                    cs_next = chain_view.head;
                end
                if (walk_wide == end_pos)
                begin
                    endb_next = chain_view.head;
                end
            end
            mfr_pkg::S_VERDICT:
            begin
                err_next  = (endb_reg != end_reg) ? mfr_pkg::ST_END : mfr_pkg::ST_CSUM;
                emit_next = '0;
            end
            mfr_pkg::S_ERR:
            begin
                if (can_load)
                begin
                    out_valid_next   = 1'b1;
                    out_byte_next    = '0;
                    out_idx_next     = '0;
                    out_last_next    = 1'b1;
                    out_status_next  = err_reg;
                    chain_ctrl.shift = 1'b1;
                    fill_next        = fill_reg - mfr_pkg::CNT_W'(1);
                    done_next        = 1'b1;
                end
            end
            mfr_pkg::S_EMIT:
            begin
                if (can_load)
                begin
                    // Emitting the head and rotating drops it from the store.
                    out_valid_next   = 1'b1;
                    out_byte_next    = chain_view.head;
                    out_idx_next     = emit_reg;
                    out_last_next    = emit_last;
                    out_status_next  = mfr_pkg::ST_FRAME;
                    chain_ctrl.shift = 1'b1;
                    fill_next        = fill_reg - mfr_pkg::CNT_W'(1);
                    emit_next        = emit_reg + mfr_pkg::BIDX_W'(1);
                    done_next        = 1'b1;
                end
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    // Configuration writes; an unknown index is ignored.
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        if (cfg_we)
        begin
            if (cfg_index == mfr_pkg::REG_START)
            begin
                start_next = cfg_data;
            end
            else if (cfg_index == mfr_pkg::REG_END)
            begin
                end_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfr_pkg::S_IDLE;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            start_reg     <= mfr_pkg::START_RESET;
            end_reg       <= mfr_pkg::END_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg       <= walk_next;
        sum_reg        <= sum_next;
        cs_reg         <= cs_next;
        endb_reg       <= endb_next;
        len_reg        <= len_next;
        err_reg        <= err_next;
        emit_reg       <= emit_next;
        out_byte_reg   <= out_byte_next;
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_idx_reg, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    // Store never holds more than its depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= mfr_pkg::CNT_W'(mfr_pkg::BUF_DEPTH))
        else $error("fill count beyond store depth");

    // An accepted byte grows the store by one.
    a_append: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (fill_reg == $past(fill_reg) + mfr_pkg::CNT_W'(1)))
        else $error("accepted byte not appended");

    // The checksum walk rotates without dropping.
    a_walk_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mfr_pkg::S_WALK) |=> (fill_reg == $past(fill_reg)))
        else $error("fill count changed during walk");

    // Error results are always single and marked last.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != mfr_pkg::ST_FRAME)) |->
        (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("error result malformed");

endmodule

`default_nettype wire

[dv/meter_frame_receiver_tb.sv]
// Self-checking testbench for the meter frame receiver: directed frames, errors and random traffic.

module meter_frame_receiver_tb;
    import mfr_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    // Worst case per input byte: 63 header drops, a checksum walk over the whole
    // store and 64 emitted bytes; SETTLE_CYCLES covers a block that is still busy.
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 1500;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_BYTES  = 20;
    localparam int IDLE_PCT      = 30;
    localparam int MAX_GOOD_LEN  = BUF_DEPTH - FRAME_OVERHEAD;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum {FRM_GOOD, FRM_BAD_SUM, FRM_BAD_END, FRM_LONG} frame_kind_t;
    typedef enum {RX_PACED, RX_STEADY, RX_HOLD} rx_pace_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [BIDX_W-1:0] pos;
        logic              last;
        status_t           status;
    } frame_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;          // [7:0] out_byte, [13:8] byte_index, [15:14] zero
    logic                 m_tlast;          // last
    logic [1:0]           m_tuser;          // [1:0] status
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_START;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    // Frame store mirror, marker settings and the results still owed by the block.
    logic [BYTE_W-1:0] frame_store [BUF_DEPTH];
    int unsigned       held_bytes;
    logic [BYTE_W-1:0] start_val = START_RESET;
    logic [BYTE_W-1:0] end_val   = END_RESET;
    frame_result_t     due_results [$];

    // Run statistics and pacing controls.
    int unsigned bytes_sent;
    int unsigned frames_due;
    int unsigned errors_due [4];
    int unsigned cfg_writes;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned hold_count;
    int          tx_idle_pct = IDLE_PCT;
    rx_pace_t    rx_pace     = RX_PACED;

    meter_frame_receiver DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Frame predictor: mirrors the frame store and owes results per byte.
    // ------------------------------------------------------------------

    // Drop n leading bytes from the store mirror.
    function automatic void drop_lead(int unsigned n);
        if (n >= held_bytes)
        begin
            held_bytes = 0;
        end
        else
        begin
            for (int unsigned i = 0; i < held_bytes - n; i++)
                frame_store[i] = frame_store[i + n];
            held_bytes -= n;
        end
    endfunction

    // Advance until the store starts with a plausible header: start byte at
    // offset 0 and, once present, at the second header position too.
    function automatic void hunt_header();
        while ((held_bytes >= 1 && frame_store[0] != start_val) ||
               (held_bytes > HDR_SECOND && frame_store[HDR_SECOND] != start_val))
            drop_lead(1);
    endfunction

    function automatic void queue_result(logic [BYTE_W-1:0] data, logic [BIDX_W-1:0] pos,
                                         logic last, status_t status);
        frame_result_t r;
        r.data   = data;
        r.pos    = pos;
        r.last   = last;
        r.status = status;
        due_results.push_back(r);
    endfunction

    // An error owes one status item, then drops the leading byte and hunts on.
    function automatic void flag_error(status_t status);
        queue_result('0, '0, 1'b1, status);
        errors_due[status]++;
        drop_lead(1);
        hunt_header();
    endfunction

    // Work out what one accepted byte makes the block emit.
    function automatic void predict_rx_byte(logic [BYTE_W-1:0] rx);
        int unsigned       len;
        int unsigned       total;
        logic [BYTE_W-1:0] sum;

        if (held_bytes >= BUF_DEPTH)
            drop_lead(held_bytes - (BUF_DEPTH - 1));
        frame_store[held_bytes] = rx;
        held_bytes++;
        hunt_header();

        if (held_bytes <= LEN_POS)
            return;
        len   = frame_store[LEN_POS];
        total = len + FRAME_OVERHEAD;
        if (total > BUF_DEPTH)
        begin
            flag_error(ST_LONG);
            return;
        end
        if (held_bytes < total)
            return;
        if (frame_store[len + END_OFFSET] != end_val)
        begin
            flag_error(ST_END);
            return;
        end
        sum = '0;
        for (int unsigned i = 0; i < len + CS_OFFSET; i++)
            sum = sum + frame_store[i];
        if (sum != frame_store[len + CS_OFFSET])
        begin
            flag_error(ST_CSUM);
            return;
        end
        for (int unsigned i = 0; i < total; i++)
            queue_result(frame_store[i], BIDX_W'(i), i + 1 == total, ST_FRAME);
        frames_due++;
        // Bytes beyond the frame stay held and get hunted through.
        drop_lead(total);
        hunt_header();
    endfunction

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offer one item and hold it until the block takes it. Valid stays high
    // after acceptance so a back-to-back item needs no second assignment in
    // the same step; anything that lets time pass afterwards lowers it first.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_rx_byte(value);
        bytes_sent++;
    endtask

    // Build one frame with the current markers, optionally broken, and send it.
    // A too-long frame stops after its length byte: the verdict comes there.
    task automatic send_frame(input frame_kind_t kind, input int unsigned len);
        logic [BYTE_W-1:0] frame_bytes [$];
        logic [BYTE_W-1:0] sum;

        frame_bytes.push_back(start_val);
        repeat (HDR_SECOND - 1) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(start_val);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'(len));
        if (kind != FRM_LONG)
        begin
            repeat (len) frame_bytes.push_back(8'($urandom));
            sum = '0;
            foreach (frame_bytes[i])
                sum = sum + frame_bytes[i];
            frame_bytes.push_back(kind == FRM_BAD_SUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
            frame_bytes.push_back(kind == FRM_BAD_END ?
                                  end_val ^ 8'($urandom_range(1, 255)) : end_val);
        end
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    // Line noise, with start bytes sprinkled in to bait the header hunt.
    task automatic send_noise(input int unsigned count);
        repeat (count)
            send_byte($urandom_range(0, 3) == 0 ? start_val : 8'($urandom));
    endtask

    // Stop offering, wait for every owed result and let the block go quiet.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [BYTE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == REG_START)
            start_val = value;
        else if (index == REG_END)
            end_val = value;
        cfg_writes++;
    endtask

    task automatic set_markers(input logic [BYTE_W-1:0] start_code,
                               input logic [BYTE_W-1:0] stop_code);
        settle_block();
        write_reg(REG_START, start_code);
        write_reg(REG_END, stop_code);
    endtask

    // ------------------------------------------------------------------
    // Receiver side and checking.
    // ------------------------------------------------------------------

    // Pace the result side; a hold-off keeps ready low for a counted stretch.
    always @(posedge clk)
    begin
        if (rx_pace == RX_HOLD && hold_count < HOLD_CYCLES)
        begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
        begin
            if (rx_pace != RX_HOLD)
                hold_count <= 0;
            m_tready <= (rx_pace == RX_STEADY) || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                 cycle_count, what, want, got);
    endtask

    // Compare one accepted result with the oldest owed one, field by field.
    task automatic check_result();
        frame_result_t want;

        results_checked++;
        if (due_results.size() == 0)
        begin
            report_mismatch("unowed result, tdata", 0, m_tdata);
        end
        else
        begin
            want = due_results.pop_front();
            if (m_tdata[BYTE_W-1:0] !== want.data)
                report_mismatch("out_byte", want.data, m_tdata[BYTE_W-1:0]);
            if (m_tdata[BYTE_W +: BIDX_W] !== want.pos)
                report_mismatch("byte_index", want.pos, m_tdata[BYTE_W +: BIDX_W]);
            if (m_tdata[15:BYTE_W+BIDX_W] !== '0)
                report_mismatch("tdata pad bits", 0, m_tdata[15:BYTE_W+BIDX_W]);
            if (m_tlast !== want.last)
                report_mismatch("last", want.last, m_tlast);
            if (m_tuser !== want.status)
                report_mismatch("status", want.status, m_tuser);
        end
    endtask

    // Sample at the edge, before any output moves.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset markers: byte extremes as noise, then a short good frame.
    task automatic test_reset_markers();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(FRM_GOOD, 0);
    endtask

    // Each error kind: bad checksum, bad end byte, length just past the store.
    task automatic test_frame_errors();
        send_frame(FRM_BAD_SUM, 0);
        send_frame(FRM_BAD_END, 0);
        send_frame(FRM_LONG, MAX_GOOD_LEN + 1);
    endtask

    // A good frame trailed by a partial header that later bytes must hunt through.
    task automatic test_trailing_bytes();
        send_frame(FRM_GOOD, 0);
        send_byte(start_val);
        send_noise(2);
    endtask

    // Marker extremes, plus writes to unused indexes that must change nothing.
    task automatic test_marker_writes();
        set_markers(8'h00, 8'hFF);
        write_reg(REG_SPARE_A, 8'h5A);
        write_reg(REG_SPARE_B, 8'hA5);
        send_frame(FRM_GOOD, 1);
    endtask

    // Hold the result side off while bytes keep coming, so the block backs up.
    task automatic test_receiver_holdoff();
        settle_block();
        rx_pace = RX_HOLD;
        send_frame(FRM_GOOD, 0);
        send_noise(2);
        settle_block();
        rx_pace = RX_PACED;
    endtask

    // Mostly well-formed frames with random content and markers; the second
    // phase runs with no idling on either side.
    task automatic test_random_traffic();
        int unsigned phase_end;
        int unsigned pick;
        int unsigned len;

        for (int p = 0; p < 2; p++)
        begin
            set_markers(8'($urandom), 8'($urandom));
            tx_idle_pct = (p == 1) ? 0 : IDLE_PCT;
            rx_pace     = (p == 1) ? RX_STEADY : RX_PACED;
            phase_end   = bytes_sent + RANDOM_BYTES / 2;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                len  = ($urandom_range(0, 11) == 0) ? $urandom_range(20, MAX_GOOD_LEN)
                                                    : $urandom_range(0, 8);
                if (pick < 60)
                    send_frame(FRM_GOOD, len);
                else if (pick < 70)
                    send_frame(FRM_BAD_SUM, len);
                else if (pick < 80)
                    send_frame(FRM_BAD_END, len);
                else if (pick < 85)
                    send_frame(FRM_LONG, $urandom_range(MAX_GOOD_LEN + 1, 255));
                else
                    send_noise($urandom_range(1, 6));
            end
        end
        tx_idle_pct = IDLE_PCT;
        rx_pace     = RX_PACED;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_markers();
        test_frame_errors();
        test_trailing_bytes();
        test_marker_writes();
        test_receiver_holdoff();
        test_random_traffic();
        settle_block();

        $display("Run covered %0d input bytes, %0d results checked, %0d register writes.",
                 bytes_sent, results_checked, cfg_writes);
        $display("Good frames %0d; checksum errors %0d, end byte errors %0d, too long %0d.",
                 frames_due, errors_due[ST_CSUM], errors_due[ST_END], errors_due[ST_LONG]);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
